[hdl/sha256_pkg.sv]
package sha256_pkg;

   // Input item kinds carried on req_tuser
   localparam logic [1:0] MODE_ABSORB  = 2'd0;
   localparam logic [1:0] MODE_FINISH  = 2'd1;
   localparam logic [1:0] MODE_RESTART = 2'd2;

   // Padding marker byte and the fill level where the length field starts
   localparam logic [7:0] PAD_MARKER  = 8'h80;
   localparam logic [5:0] LEN_START   = 6'd56;
   localparam logic [5:0] FILL_LAST   = 6'd63;
   localparam logic [5:0] ROUND_LAST  = 6'd63;
   localparam logic [2:0] WORD_LAST   = 3'd7;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD_MARK,
      ST_PAD_FILL,
      ST_PAD_LEN,
      ST_ROUND,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   // Controls for the message buffer / schedule
   typedef struct packed {
      logic       push;
      logic [7:0] push_byte;
      logic       step;
   } sched_ctrl_type;

   // Controls for the round unit and hash words
   typedef struct packed {
      logic init_hash;
      logic load_vars;
      logic do_round;
      logic do_update;
   } round_ctrl_type;

   // Rotate right by a constant amount
   function automatic logic [31:0] rotr32(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

[hdl/sha256_message_digest.sv]
// Absorb: one byte a cycle while idle; the byte that fills a block starts 64 rounds + update.
// Finish: padding (marker, zeros, 64-bit length) goes one byte a cycle through the block buffer,
// rounds one a cycle; with 56 or more bytes pending, the padding spans an extra block.
// Digest: eight words, one per accepted output cycle; the engine then reinitializes.
// Restart reinitializes; mode 3 is ignored. Synchronous active-high reset gives the initial hash.
module sha256_message_digest (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
   output logic        rsp_tlast    // last_word
);

   sha256_pkg::state_type      state_ff, state_in;
   sha256_pkg::state_type      resume_ff, resume_in;
   sha256_pkg::sched_ctrl_type sched_ctrl;
   sha256_pkg::round_ctrl_type round_ctrl;

   logic [5:0]  fill_ff, fill_in;
   logic [63:0] count_ff, count_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  idx_ff, idx_in;
   logic [63:0] bit_len;
   logic [63:0] len_shift;
   logic [31:0] w_t;
   logic [31:0] hash_word;
   logic        req_acc;
   logic        rsp_acc;
   logic        block_full;
   logic        reinit;

   // Length field, most significant byte first
   assign bit_len   = {count_ff[60:0], 3'b000};
   assign len_shift = bit_len >> {~idx_ff, 3'b000};

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   // Output decode
   always_comb begin
      req_tready           = (state_ff == sha256_pkg::ST_IDLE);
      rsp_tvalid           = (state_ff == sha256_pkg::ST_EMIT);
      sched_ctrl.push      = 1'b0;
      sched_ctrl.push_byte = 8'h00;
      sched_ctrl.step      = (state_ff == sha256_pkg::ST_ROUND);
      unique case (state_ff)
         sha256_pkg::ST_IDLE: begin
            sched_ctrl.push      = req_acc && (req_tuser == sha256_pkg::MODE_ABSORB);
            sched_ctrl.push_byte = req_tdata;
         end
         sha256_pkg::ST_PAD_MARK: begin
            sched_ctrl.push      = 1'b1;
            sched_ctrl.push_byte = sha256_pkg::PAD_MARKER;
         end
         sha256_pkg::ST_PAD_FILL: begin
            sched_ctrl.push = (fill_ff != sha256_pkg::LEN_START);
         end
         sha256_pkg::ST_PAD_LEN: begin
            sched_ctrl.push      = 1'b1;
            sched_ctrl.push_byte = len_shift[7:0];
         end
         default: begin
         end
      endcase
      block_full = sched_ctrl.push && (fill_ff == sha256_pkg::FILL_LAST);
      reinit     = (req_acc && (req_tuser == sha256_pkg::MODE_RESTART))
                   || (rsp_acc && (idx_ff == sha256_pkg::WORD_LAST));
      round_ctrl.init_hash = reinit;
      round_ctrl.load_vars = block_full;
      round_ctrl.do_round  = (state_ff == sha256_pkg::ST_ROUND);
      round_ctrl.do_update = (state_ff == sha256_pkg::ST_UPDATE);
      rsp_tdata = {5'b00000, idx_ff, hash_word};
      rsp_tlast = (idx_ff == sha256_pkg::WORD_LAST);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha256_pkg::ST_IDLE: begin
            if (block_full) begin
               state_in = sha256_pkg::ST_ROUND;
            end else if (req_acc && (req_tuser == sha256_pkg::MODE_FINISH)) begin
               state_in = sha256_pkg::ST_PAD_MARK;
            end
         end
         sha256_pkg::ST_PAD_MARK: begin
            state_in = block_full ? sha256_pkg::ST_ROUND : sha256_pkg::ST_PAD_FILL;
         end
         sha256_pkg::ST_PAD_FILL: begin
            if (fill_ff == sha256_pkg::LEN_START) begin
               state_in = sha256_pkg::ST_PAD_LEN;
            end else if (block_full) begin
               state_in = sha256_pkg::ST_ROUND;
            end
         end
         sha256_pkg::ST_PAD_LEN: begin
            if (block_full) begin
               state_in = sha256_pkg::ST_ROUND;
            end
         end
         sha256_pkg::ST_ROUND: begin
            if (round_ff == sha256_pkg::ROUND_LAST) begin
               state_in = sha256_pkg::ST_UPDATE;
            end
         end
         sha256_pkg::ST_UPDATE: begin
            state_in = resume_ff;
         end
         sha256_pkg::ST_EMIT: begin
            if (rsp_acc && (idx_ff == sha256_pkg::WORD_LAST)) begin
               state_in = sha256_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sha256_pkg::ST_IDLE;
         end
      endcase
   end

   // Counters and the state to return to after a block
   always_comb begin
      resume_in = resume_ff;
      if (block_full) begin
         unique case (state_ff)
            sha256_pkg::ST_IDLE:    resume_in = sha256_pkg::ST_IDLE;
            sha256_pkg::ST_PAD_LEN: resume_in = sha256_pkg::ST_EMIT;
            default:                resume_in = sha256_pkg::ST_PAD_FILL;
         endcase
      end

      fill_in = fill_ff;
      if (reinit) begin
         fill_in = 6'd0;
      end else if (sched_ctrl.push) begin
         fill_in = fill_ff + 6'd1;
      end

      count_in = count_ff;
      if (reinit) begin
         count_in = 64'd0;
      end else if (req_acc && (req_tuser == sha256_pkg::MODE_ABSORB)) begin
         count_in = count_ff + 64'd1;
      end

      round_in = (state_ff == sha256_pkg::ST_ROUND) ? round_ff + 6'd1 : round_ff;

      idx_in = idx_ff;
      if (((state_ff == sha256_pkg::ST_PAD_LEN) && sched_ctrl.push) || rsp_acc) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sha256_pkg::ST_IDLE;
         resume_ff <= sha256_pkg::ST_IDLE;
         fill_ff   <= 6'd0;
         count_ff  <= 64'd0;
         round_ff  <= 6'd0;
         idx_ff    <= 3'd0;
      end else begin
         state_ff  <= state_in;
         resume_ff <= resume_in;
         fill_ff   <= fill_in;
         count_ff  <= count_in;
         round_ff  <= round_in;
         idx_ff    <= idx_in;
      end
   end

   sha256_sched u_sched (
      .clock (clock),
      .ctrl  (sched_ctrl),
      .w_t   (w_t)
   );

   sha256_round u_round (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (round_ctrl),
      .w_t       (w_t),
      .round_idx (round_ff),
      .rd_idx    (idx_ff),
      .hash_word (hash_word)
   );

endmodule

[hdl/sha256_sched.sv]
module sha256_sched (
   input  logic                      clock,
   input  sha256_pkg::sched_ctrl_type ctrl,
   output logic [31:0]               w_t
);

   // Word 0 sits in the top bits; bytes enter at the bottom
   logic [511:0] msg_ff;
   logic [511:0] msg_in;
   logic [31:0]  w1;
   logic [31:0]  w9;
   logic [31:0]  w14;
   logic [31:0]  sig0;
   logic [31:0]  sig1;
   logic [31:0]  w_new;

   assign w_t = msg_ff[511:480];
   assign w1  = msg_ff[479:448];
   assign w9  = msg_ff[223:192];
   assign w14 = msg_ff[63:32];

   // Expand the next schedule word from the rolling window
   always_comb begin
      sig0  = sha256_pkg::rotr32(w1, 7) ^ sha256_pkg::rotr32(w1, 18) ^ (w1 >> 3);
      sig1  = sha256_pkg::rotr32(w14, 17) ^ sha256_pkg::rotr32(w14, 19) ^ (w14 >> 10);
      w_new = w_t + sig0 + w9 + sig1;
   end

   // Shift in a byte while filling, roll by a word while compressing
   always_comb begin
      msg_in = msg_ff;
      if (ctrl.push) begin
         msg_in = {msg_ff[503:0], ctrl.push_byte};
      end else if (ctrl.step) begin
         msg_in = {msg_ff[479:0], w_new};
      end
   end

   always_ff @(posedge clock) begin
      msg_ff <= msg_in;
   end

endmodule

[hdl/sha256_round.sv]
module sha256_round (
   input  logic                      clock,
   input  logic                      reset,
   input  sha256_pkg::round_ctrl_type ctrl,
   input  logic [31:0]               w_t,
   input  logic [5:0]                round_idx,
   input  logic [2:0]                rd_idx,
   output logic [31:0]               hash_word
);

   logic [31:0] hash_ff [8];
   logic [31:0] var_ff  [8];
   logic [31:0] big0;
   logic [31:0] big1;
   logic [31:0] ch;
   logic [31:0] maj;
   logic [31:0] tmp1;
   logic [31:0] tmp2;

   assign hash_word = hash_ff[rd_idx];

   // One compression round
   always_comb begin
      big1 = sha256_pkg::rotr32(var_ff[4], 6) ^ sha256_pkg::rotr32(var_ff[4], 11)
             ^ sha256_pkg::rotr32(var_ff[4], 25);
      ch   = (var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]);
      tmp1 = var_ff[7] + big1 + ch + sha256_pkg::ROUND_K[round_idx] + w_t;
      big0 = sha256_pkg::rotr32(var_ff[0], 2) ^ sha256_pkg::rotr32(var_ff[0], 13)
             ^ sha256_pkg::rotr32(var_ff[0], 22);
      maj  = (var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]);
      tmp2 = big0 + maj;
   end

   // Hash words: reinitialize, or fold in the working variables after a block
   always_ff @(posedge clock) begin
      if (reset || ctrl.init_hash) begin
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= sha256_pkg::INIT_HASH[i];
         end
      end else if (ctrl.do_update) begin
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= hash_ff[i] + var_ff[i];
         end
      end
   end

   // Working variables: load from the hash words, then advance one round a cycle
   always_ff @(posedge clock) begin
      if (ctrl.load_vars) begin
         for (int i = 0; i < 8; i++) begin
            var_ff[i] <= hash_ff[i];
         end
      end else if (ctrl.do_round) begin
         var_ff[0] <= tmp1 + tmp2;
         var_ff[1] <= var_ff[0];
         var_ff[2] <= var_ff[1];
         var_ff[3] <= var_ff[2];
         var_ff[4] <= var_ff[3] + tmp1;
         var_ff[5] <= var_ff[4];
         var_ff[6] <= var_ff[5];
         var_ff[7] <= var_ff[6];
      end
   end

endmodule
